[hw/rtl/restricted_circular_deque_defines.svh]
// Assertion macros for the restricted deque.
`ifndef RESTRICTED_CIRCULAR_DEQUE_DEFINES_SVH
`define RESTRICTED_CIRCULAR_DEQUE_DEFINES_SVH

// Condition in the same cycle.
`define RCD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rcd assertion failed");

// Condition in the next cycle.
`define RCD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rcd assertion failed");

`endif

[hw/rtl/rcd_pkg.sv]
`default_nettype none

package rcd_pkg;

    localparam int DATA_W        = 32;
    localparam int APB_W         = 32;
    localparam int OCC_W         = 4;
    localparam int DEFAULT_DEPTH = 8;
    localparam int PADDR_W       = 3;

    // register index, taken from paddr above the byte offset
    localparam logic [PADDR_W-3:0] REG_MODE = '0;

    typedef enum logic [1:0] {
        REQ_INS_RIGHT,
        REQ_INS_LEFT,
        REQ_DEL_LEFT,
        REQ_DEL_RIGHT
    } t_req;

    typedef enum logic [1:0] {
        ST_OK,
        ST_OVERFLOW,
        ST_UNDERFLOW,
        ST_DENIED
    } t_status;

    typedef enum logic {
        MODE_IN_RESTRICTED,
        MODE_OUT_RESTRICTED
    } t_mode;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_TAKE_LO,
        CELL_TAKE_HI,
        CELL_LOAD
    } t_cell_op;

endpackage

`default_nettype wire

[hw/rtl/restricted_circular_deque.sv]
// Restricted double-ended queue of DEPTH 32-bit elements.
// Input channel (i_in_valid/o_in_ready) carries one request per beat: a
// request type and a value to insert. Output channel (o_out_valid/
// i_out_ready) returns exactly one result beat per request: the removed
// element (zero unless a delete succeeded), a status code and the
// occupancy after the request.
// The result beat is registered and appears in the cycle after the input
// beat; one request per cycle is sustained while the receiver is ready, set by the single output register.
// The elements live in two rows of cells, one packed from the left end and
// one from the right end, so both ends are read at a fixed cell; every
// request is, in each row, a whole-row shift, a single-cell load or a hold.
// The APB port holds the restriction mode at address 0; write it only
// while no request is outstanding.
// Reset empties the queue, clears the mode to input-restricted and drops
// any pending result. While the receiver stalls the result is held and no
// new request is taken.
`default_nettype none

`include "restricted_circular_deque_defines.svh"

module restricted_circular_deque #(
    parameter int DEPTH = rcd_pkg::DEFAULT_DEPTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,

    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [1:0]                     i_req_type,
    input  wire logic signed [rcd_pkg::DATA_W-1:0] i_value,

    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic signed [rcd_pkg::DATA_W-1:0]   o_removed_value,
    output logic      [1:0]                     o_status,
    output logic      [rcd_pkg::OCC_W-1:0]      o_occupancy,

    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [rcd_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [rcd_pkg::APB_W-1:0]      pwdata,
    output logic      [rcd_pkg::APB_W-1:0]      prdata,
    output logic                                pready
);
    import rcd_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int POS_W = $clog2(DEPTH);

    t_mode              r_mode;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_out_valid;
    logic [DATA_W-1:0]  r_removed;
    logic [DATA_W-1:0]  n_removed;
    t_status            r_status;
    t_status            n_status;
    logic [OCC_W-1:0]   r_occ;

    t_req               w_req;
    logic               w_fire;
    logic               w_is_ins;
    logic               w_denied;
    logic               w_ok;
    t_cell_op           w_lrow_op;
    t_cell_op           w_rrow_op;
    logic [POS_W-1:0]   w_pos;
    logic [DATA_W-1:0]  w_left_end;
    logic [DATA_W-1:0]  w_right_end;
    logic               w_reg_sel;

    // config port
    assign pready    = 1'b1;
    assign w_reg_sel = (paddr[PADDR_W-1:2] == REG_MODE);
    assign prdata    = w_reg_sel ? APB_W'(r_mode) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IN_RESTRICTED;
        end else if (psel && penable && pwrite && pready && w_reg_sel) begin
            r_mode <= t_mode'(pwdata[0]);
        end
    end

    // request decode
    assign o_in_ready = i_rst_n && (!r_out_valid || i_out_ready);
    assign w_fire     = i_in_valid && o_in_ready;
    assign w_req      = t_req'(i_req_type);
    assign w_is_ins   = (w_req == REQ_INS_RIGHT) || (w_req == REQ_INS_LEFT);
    assign w_denied   = (r_mode == MODE_IN_RESTRICTED && w_req == REQ_INS_LEFT) ||
                        (r_mode == MODE_OUT_RESTRICTED && w_req == REQ_DEL_RIGHT);
    assign w_pos      = r_count[POS_W-1:0];

    always_comb begin
        if (w_denied) begin
            n_status = ST_DENIED;
        end else if (w_is_ins && r_count == CNT_W'(DEPTH)) begin
            n_status = ST_OVERFLOW;
        end else if (!w_is_ins && r_count == '0) begin
            n_status = ST_UNDERFLOW;
        end else begin
            n_status = ST_OK;
        end
    end

    assign w_ok = w_fire && (n_status == ST_OK);

    // left row: cell 0 = leftmost; right row: cell 0 = rightmost
    always_comb begin
        w_lrow_op = CELL_HOLD;
        w_rrow_op = CELL_HOLD;
        n_count   = r_count;
        n_removed = '0;
        if (w_ok) begin
            case (w_req)
                REQ_INS_RIGHT: begin
                    w_lrow_op = CELL_LOAD;
                    w_rrow_op = CELL_TAKE_LO;
                    n_count   = r_count + 1'b1;
                end
                REQ_INS_LEFT: begin
                    w_lrow_op = CELL_TAKE_LO;
                    w_rrow_op = CELL_LOAD;
                    n_count   = r_count + 1'b1;
                end
                REQ_DEL_LEFT: begin
                    w_lrow_op = CELL_TAKE_HI;
                    n_count   = r_count - 1'b1;
                    n_removed = w_left_end;
                end
                REQ_DEL_RIGHT: begin
                    w_rrow_op = CELL_TAKE_HI;
                    n_count   = r_count - 1'b1;
                    n_removed = w_right_end;
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end
    end

    rcd_row #(.DEPTH(DEPTH)) u_left_row (
        .i_clk      (i_clk),
        .i_op       (w_lrow_op),
        .i_pos      (w_pos),
        .i_value    (i_value),
        .o_end_data (w_left_end)
    );

    rcd_row #(.DEPTH(DEPTH)) u_right_row (
        .i_clk      (i_clk),
        .i_op       (w_rrow_op),
        .i_pos      (w_pos),
        .i_value    (i_value),
        .o_end_data (w_right_end)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_removed <= n_removed;
            r_status  <= n_status;
            r_occ     <= OCC_W'(n_count);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_removed_value = r_removed;
    assign o_status        = r_status;
    assign o_occupancy     = r_occ;

    `RCD_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CNT_W'(DEPTH))
    `RCD_ASSERT_NEXT(a_ins_grows, w_ok && w_is_ins, r_count == $past(r_count) + 1'b1)
    `RCD_ASSERT_NOW(a_ovf_full, r_out_valid && r_status == ST_OVERFLOW, r_count == CNT_W'(DEPTH))
    `RCD_ASSERT_NOW(a_udf_empty, r_out_valid && r_status == ST_UNDERFLOW, r_count == '0)

endmodule

`default_nettype wire

[hw/rtl/rcd_cell.sv]
`default_nettype none

module rcd_cell (
    input  wire logic                         i_clk,
    input  wire rcd_pkg::t_cell_op            i_op,
    input  wire logic [rcd_pkg::DATA_W-1:0]   i_lo_data,
    input  wire logic [rcd_pkg::DATA_W-1:0]   i_hi_data,
    input  wire logic [rcd_pkg::DATA_W-1:0]   i_value,
    output logic      [rcd_pkg::DATA_W-1:0]   o_data
);
    import rcd_pkg::*;

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;

    always_comb begin
        case (i_op)
            CELL_TAKE_LO: n_data = i_lo_data;
            CELL_TAKE_HI: n_data = i_hi_data;
            CELL_LOAD:    n_data = i_value;
            default:      n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

[hw/rtl/rcd_row.sv]
`default_nettype none

// Packed row: cell 0 is the near end, elements fill upwards.
module rcd_row #(
    parameter int DEPTH = rcd_pkg::DEFAULT_DEPTH
) (
    input  wire logic                           i_clk,
    input  wire rcd_pkg::t_cell_op              i_op,
    input  wire logic [$clog2(DEPTH)-1:0]       i_pos,
    input  wire logic [rcd_pkg::DATA_W-1:0]     i_value,
    output logic      [rcd_pkg::DATA_W-1:0]     o_end_data
);
    import rcd_pkg::*;

    localparam int POS_W = $clog2(DEPTH);

    logic [DATA_W-1:0] w_data [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_cell_op          w_op;
        logic [DATA_W-1:0] w_lo;
        logic [DATA_W-1:0] w_hi;

        always_comb begin
            if (i_op == CELL_LOAD) begin
                w_op = (i_pos == POS_W'(g)) ? CELL_LOAD : CELL_HOLD;
            end else begin
                w_op = i_op;
            end
        end

        if (g == 0) begin : g_first
            assign w_lo = i_value;
        end else begin : g_mid_lo
            assign w_lo = w_data[g-1];
        end

        if (g == DEPTH-1) begin : g_last
            assign w_hi = i_value;
        end else begin : g_mid_hi
            assign w_hi = w_data[g+1];
        end

        rcd_cell u_cell (
            .i_clk     (i_clk),
            .i_op      (w_op),
            .i_lo_data (w_lo),
            .i_hi_data (w_hi),
            .i_value   (i_value),
            .o_data    (w_data[g])
        );
    end

    assign o_end_data = w_data[0];

endmodule

`default_nettype wire

[verif/tb.sv]
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rcd_pkg::*;

    localparam int DEPTH = DEFAULT_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);

    typedef struct packed {
        logic [DATA_W-1:0] removed;
        t_status           status;
        logic [OCC_W-1:0]  occ;
    } t_result;

    typedef struct packed {
        t_mode             mode;
        t_req              req;
        logic [DATA_W-1:0] value;
        bit                typed;
        t_result           res;
    } t_row;

    localparam t_result UNTYPED = '{32'h0, ST_OK, 4'd0};

    localparam t_row DIRECTED [22] = '{
        '{MODE_IN_RESTRICTED,  REQ_DEL_LEFT,  32'hFFFF_FFFF, 1'b1, '{32'h0, ST_UNDERFLOW, 4'd0}},
        '{MODE_IN_RESTRICTED,  REQ_DEL_RIGHT, 32'h0000_0000, 1'b1, '{32'h0, ST_UNDERFLOW, 4'd0}},
        '{MODE_IN_RESTRICTED,  REQ_INS_LEFT,  32'h0000_0001, 1'b1, '{32'h0, ST_DENIED,    4'd0}},
        '{MODE_IN_RESTRICTED,  REQ_INS_RIGHT, 32'h7FFF_FFFF, 1'b1, '{32'h0, ST_OK,        4'd1}},
        '{MODE_IN_RESTRICTED,  REQ_DEL_RIGHT, 32'h0000_0000, 1'b1,
            '{32'h7FFF_FFFF, ST_OK, 4'd0}},
        '{MODE_IN_RESTRICTED,  REQ_INS_RIGHT, 32'h8000_0000, 1'b1, '{32'h0, ST_OK,        4'd1}},
        '{MODE_IN_RESTRICTED,  REQ_INS_RIGHT, 32'hFFFF_FFFF, 1'b0, UNTYPED},
        '{MODE_IN_RESTRICTED,  REQ_INS_RIGHT, 32'h0000_0000, 1'b0, UNTYPED},
        '{MODE_IN_RESTRICTED,  REQ_INS_RIGHT, 32'h5555_5555, 1'b0, UNTYPED},
        '{MODE_IN_RESTRICTED,  REQ_INS_RIGHT, 32'hAAAA_AAAA, 1'b0, UNTYPED},
        '{MODE_IN_RESTRICTED,  REQ_INS_RIGHT, 32'h0000_0001, 1'b0, UNTYPED},
        '{MODE_IN_RESTRICTED,  REQ_INS_RIGHT, 32'h1234_5678, 1'b0, UNTYPED},
        '{MODE_IN_RESTRICTED,  REQ_INS_RIGHT, 32'h7FFF_FFFE, 1'b1, '{32'h0, ST_OK,        4'd8}},
        '{MODE_IN_RESTRICTED,  REQ_INS_RIGHT, 32'hDEAD_BEEF, 1'b1, '{32'h0, ST_OVERFLOW,  4'd8}},
        '{MODE_IN_RESTRICTED,  REQ_DEL_LEFT,  32'h0000_0000, 1'b1,
            '{32'h8000_0000, ST_OK, 4'd7}},
        '{MODE_IN_RESTRICTED,  REQ_INS_RIGHT, 32'h0F0F_0F0F, 1'b0, UNTYPED},
        '{MODE_OUT_RESTRICTED, REQ_DEL_RIGHT, 32'h0000_0000, 1'b1, '{32'h0, ST_DENIED,    4'd8}},
        '{MODE_OUT_RESTRICTED, REQ_INS_LEFT,  32'h8000_0001, 1'b1, '{32'h0, ST_OVERFLOW,  4'd8}},
        '{MODE_OUT_RESTRICTED, REQ_DEL_LEFT,  32'h0000_0000, 1'b0, UNTYPED},
        '{MODE_OUT_RESTRICTED, REQ_DEL_LEFT,  32'h0000_0000, 1'b0, UNTYPED},
        '{MODE_OUT_RESTRICTED, REQ_INS_LEFT,  32'hF0F0_F0F0, 1'b0, UNTYPED},
        '{MODE_OUT_RESTRICTED, REQ_DEL_LEFT,  32'h0000_0000, 1'b0, UNTYPED}
    };

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_ready;
    logic [1:0]                i_req_type;
    logic signed [DATA_W-1:0]  i_value;
    logic                      o_out_valid;
    logic                      i_out_ready;
    logic signed [DATA_W-1:0]  o_removed_value;
    logic [1:0]                o_status;
    logic [OCC_W-1:0]          o_occupancy;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [PADDR_W-1:0]        paddr;
    logic [APB_W-1:0]          pwdata;
    logic [APB_W-1:0]          prdata;
    logic                      pready;

    restricted_circular_deque #(.DEPTH(DEPTH)) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_req_type      (i_req_type),
        .i_value         (i_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_removed_value (o_removed_value),
        .o_status        (o_status),
        .o_occupancy     (o_occupancy),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // shadow deque; DEPTH is a power of two so pointers wrap by width
    logic [DATA_W-1:0] shadow_cells [DEPTH];
    logic [PTR_W-1:0]  left_ptr  = '0;
    logic [PTR_W-1:0]  right_ptr = '0;
    bit                shadow_empty = 1'b1;
    t_mode             mode_now = MODE_IN_RESTRICTED;

    t_result pending_results [$];
    int      mismatches = 0;
    int      burst_left = 0;
    bit      steady = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #400us;
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic [OCC_W-1:0] held_count();
        if (shadow_empty)
            return '0;
        return OCC_W'(PTR_W'(right_ptr - left_ptr)) + 1'b1;
    endfunction

    function automatic bit forbidden(t_req r);
        return (mode_now == MODE_IN_RESTRICTED && r == REQ_INS_LEFT) ||
               (mode_now == MODE_OUT_RESTRICTED && r == REQ_DEL_RIGHT);
    endfunction

    function automatic t_result deque_step(t_req r, logic [DATA_W-1:0] v);
        t_result res;
        res = UNTYPED;
        if (forbidden(r)) begin
            res.status = ST_DENIED;
        end else if (r == REQ_INS_RIGHT || r == REQ_INS_LEFT) begin
            if (held_count() == DEPTH) begin
                res.status = ST_OVERFLOW;
            end else if (shadow_empty) begin
                left_ptr        = '0;
                right_ptr       = '0;
                shadow_empty    = 1'b0;
                shadow_cells[0] = v;
            end else if (r == REQ_INS_RIGHT) begin
                right_ptr               = right_ptr + 1'b1;
                shadow_cells[right_ptr] = v;
            end else begin
                left_ptr               = left_ptr - 1'b1;
                shadow_cells[left_ptr] = v;
            end
        end else if (shadow_empty) begin
            res.status = ST_UNDERFLOW;
        end else begin
            res.removed = (r == REQ_DEL_LEFT) ? shadow_cells[left_ptr] : shadow_cells[right_ptr];
            if (left_ptr == right_ptr) begin
                shadow_empty = 1'b1;
                left_ptr     = '0;
                right_ptr    = '0;
            end else if (r == REQ_DEL_LEFT) begin
                left_ptr = left_ptr + 1'b1;
            end else begin
                right_ptr = right_ptr - 1'b1;
            end
        end
        res.occ = held_count();
        return res;
    endfunction

    task automatic send_beat(t_req r, logic [DATA_W-1:0] v, bit typed, t_result typed_res);
        int      gap;
        t_result predicted;
        if (!steady && burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        if (burst_left > 0)
            burst_left--;
        i_in_valid <= 1'b1;
        i_req_type <= r;
        i_value    <= v;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = deque_step(r, v);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_mode(t_mode m);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_MODE, 2'b00};
        pwdata  <= {{(APB_W-1){1'b0}}, m};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        mode_now = m;
    endtask

    // receiver: ready runs broken by stalls outside steady stretches, now and then a long one
    initial begin
        int run;
        i_out_ready <= 1'b0;
        forever begin
            run = $urandom_range(1, 10);
            repeat (run) begin
                @(posedge i_clk);
                i_out_ready <= 1'b1;
            end
            if (!steady) begin
                run = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 5);
                repeat (run) begin
                    @(posedge i_clk);
                    i_out_ready <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: removed %h status %0d occ %0d",
                             o_removed_value, o_status, o_occupancy);
            end else begin
                want = pending_results.pop_front();
                if (o_removed_value !== want.removed || o_status !== want.status ||
                    o_occupancy !== want.occ) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: removed %h status %0d occ %0d, want %h %0d %0d",
                                 o_removed_value, o_status, o_occupancy,
                                 want.removed, want.status, want.occ);
                end
            end
        end
    end

    initial begin
        int                sent;
        int                chunk;
        int                ins_pct;
        t_req              r;
        logic [DATA_W-1:0] v;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_req_type <= REQ_INS_RIGHT;
        i_value    <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[i]) begin
            if (DIRECTED[i].mode != mode_now) begin
                settle();
                write_mode(DIRECTED[i].mode);
            end
            send_beat(DIRECTED[i].req, DIRECTED[i].value, DIRECTED[i].typed, DIRECTED[i].res);
        end

        // fill-heavy, drain-heavy and mixed stretches so both full and empty are hit often
        for (int ph = 0; ph < 4; ph++) begin
            settle();
            write_mode(ph[0] ? MODE_IN_RESTRICTED : MODE_OUT_RESTRICTED);
            sent = 0;
            while (sent < 150) begin
                chunk = $urandom_range(8, 30);
                case ($urandom_range(0, 2))
                    0: ins_pct = 85;
                    1: ins_pct = 50;
                    default: ins_pct = 15;
                endcase
                steady = ($urandom_range(0, 3) == 0);
                repeat (chunk) begin
                    if ($urandom_range(0, 99) < ins_pct)
                        r = $urandom_range(0, 1) ? REQ_INS_LEFT : REQ_INS_RIGHT;
                    else
                        r = $urandom_range(0, 1) ? REQ_DEL_RIGHT : REQ_DEL_LEFT;
                    if (forbidden(r) && $urandom_range(0, 3) != 0)
                        r = (r == REQ_INS_LEFT) ? REQ_INS_RIGHT : REQ_DEL_LEFT;
                    case ($urandom_range(0, 9))
                        0: v = 32'h8000_0000;
                        1: v = 32'h7FFF_FFFF;
                        2: v = 32'hFFFF_FFFF;
                        3: v = 32'h0000_0000;
                        default: v = $urandom;
                    endcase
                    send_beat(r, v, 1'b0, UNTYPED);
                    sent++;
                end
            end
        end
        steady = 1'b0;

        settle();
        if (mismatches == 0 && pending_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
